// ----- rtl/iidl_pkg.sv -----
// ----------------------------------------------------------------------------
// iidl_pkg
// Shared types and codes for the indexed insert/delete list core.
// ----------------------------------------------------------------------------
package iidl_pkg;

    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned POS_W    = 32;
    localparam int unsigned KIND_W   = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LENOUT_W = 7;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_HEAD   = 3'd1,
        KIND_TAIL   = 3'd2,
        KIND_INSERT = 3'd3,
        KIND_DELETE = 3'd4
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // open a slot at the index, shift later entries up
        logic del;   // drop the entry at the index, shift later entries down
    } cell_ctrl_t;

endpackage

// ----- rtl/iidl_cell.sv -----
// ----------------------------------------------------------------------------
// iidl_cell
// One list slot: holds an entry, shifts toward either neighbor, and taps its
// value onto the read bus when addressed.
// ----------------------------------------------------------------------------
module iidl_cell #(
    parameter int unsigned IDX_W = 7,
    parameter int unsigned INDEX = 0
) (
    input  logic                          aclk,
    input  iidl_pkg::cell_ctrl_t          ctrl,
    input  logic [IDX_W-1:0]              at,
    input  logic [iidl_pkg::VALUE_W-1:0]  new_value,
    input  logic [iidl_pkg::VALUE_W-1:0]  left_value,
    input  logic [iidl_pkg::VALUE_W-1:0]  right_value,
    output logic [iidl_pkg::VALUE_W-1:0]  value,
    output logic [iidl_pkg::VALUE_W-1:0]  tap
);

    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(INDEX);

    logic [iidl_pkg::VALUE_W-1:0] value_reg;
    logic [iidl_pkg::VALUE_W-1:0] value_next;
    logic                         hit;

    assign hit = (at == MY_IDX);

    always_comb begin
        value_next = value_reg;
        priority if (ctrl.ins) begin
            if (hit) begin
                value_next = new_value;
            end else if (at < MY_IDX) begin
                value_next = left_value;
            end
        end else if (ctrl.del) begin
            if (at <= MY_IDX) begin
                value_next = right_value;
            end
        end
    end

    always_ff @(posedge aclk) begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign tap   = hit ? value_reg : '0;

endmodule

// ----- rtl/indexed_insert_delete_list_core.sv -----
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core
// Ordered list of signed 32-bit values with read, insert and delete by
// position, held in a chain of shifting cells.
// ----------------------------------------------------------------------------
//
//  Channel | Dir | Handshake          | Payload (low bit first)
//  --------+-----+--------------------+-------------------------------------
//  s_      | in  | s_tvalid/s_tready  | tuser: kind[2:0]
//          |     |                    | tdata: position[31:0], item_value[63:32]
//  m_      | out | m_tvalid/m_tready  | tdata: read_value[31:0], status[33:32],
//          |     |                    |        length_now[40:34], zero pad
//
//  - One request beat per cycle while s_tready is high; the result
//    is registered and valid in the cycle after the beat. The cell
//    chain shifts in one step, every cell at once on insert or delete.
//  - s_tready is high whenever the result register is empty or being
//    drained, so a stalled m_ side holds one result and then stalls s_.
//  - Reset (aresetn low, synchronous) empties the list and the result
//    register; cell contents are not cleared, only slots below the length
//    are ever read.
//
module indexed_insert_delete_list_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // position[31:0], item_value[63:32]
    input  logic [2:0]  s_tuser,   // kind[2:0]

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata    // read_value[31:0], status[33:32],
                                   // length_now[40:34], zeros[47:41]
);

    localparam int unsigned LEN_W = $clog2(CAPACITY + 1);
    localparam int unsigned VW    = iidl_pkg::VALUE_W;
    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);

    // ---------------- state ----------------
    logic [LEN_W-1:0]  len_reg;
    logic [LEN_W-1:0]  len_next;
    logic              out_valid_reg;
    logic [VW-1:0]     out_rd_reg;
    logic [VW-1:0]     out_rd_next;
    iidl_pkg::status_t out_st_reg;
    iidl_pkg::status_t out_st_next;

    // ---------------- request decode ----------------
    logic                     accept;
    logic signed [31:0]       pos;
    logic [VW-1:0]            item_value;
    logic                     pos_neg;
    logic                     pos_lt_len;
    logic                     pos_eq_len;
    logic                     pos_le0;
    logic                     pos_in_range;
    logic                     full;
    logic [LEN_W-1:0]         pos_idx;
    logic [LEN_W-1:0]         at;
    logic                     do_ins;
    logic                     do_del;
    iidl_pkg::cell_ctrl_t     ctrl;
    logic [VW-1:0]            rd_bus;

    assign s_tready   = !out_valid_reg || m_tready;
    assign accept     = s_tvalid && s_tready;
    assign pos        = s_tdata[31:0];
    assign item_value = s_tdata[63:32];

    // Position compares against the current length, signed position.
    assign pos_neg      = pos[31];
    assign pos_lt_len   = !pos_neg && ({1'b0, pos} < 33'(len_reg));
    assign pos_eq_len   = !pos_neg && ({1'b0, pos} == 33'(len_reg));
    assign pos_le0      = pos_neg || (pos == 32'sd0);
    assign pos_in_range = pos_lt_len;
    assign full         = (len_reg == CAP_LEN);
    assign pos_idx      = pos[LEN_W-1:0];

    always_comb begin
        at          = pos_idx;
        do_ins      = 1'b0;
        do_del      = 1'b0;
        out_rd_next = '0;
        out_st_next = iidl_pkg::ST_DONE;
        unique case (s_tuser)
            iidl_pkg::KIND_READ: begin
                if (pos_in_range) begin
                    out_rd_next = rd_bus;
                end else begin
                    out_rd_next = '1;   // -1
                    out_st_next = iidl_pkg::ST_RANGE;
                end
            end
            iidl_pkg::KIND_HEAD: begin
                at     = '0;
                do_ins = 1'b1;
            end
            iidl_pkg::KIND_TAIL: begin
                at     = len_reg;
                do_ins = 1'b1;
            end
            iidl_pkg::KIND_INSERT: begin
                // Append wins over head, beyond the length is rejected
                // before the full check.
                priority if (pos_eq_len) begin
                    at     = len_reg;
                    do_ins = 1'b1;
                end else if (pos_le0) begin
                    at     = '0;
                    do_ins = 1'b1;
                end else if (!pos_lt_len) begin
                    out_st_next = iidl_pkg::ST_RANGE;
                end else begin
                    do_ins = 1'b1;
                end
            end
            iidl_pkg::KIND_DELETE: begin
                if (pos_in_range) begin
                    do_del = 1'b1;
                end else begin
                    out_st_next = iidl_pkg::ST_RANGE;
                end
            end
            default: begin
                out_st_next = iidl_pkg::ST_RANGE;
            end
        endcase

        // Full list drops any insert that would otherwise go through.
        if (do_ins && full) begin
            do_ins      = 1'b0;
            out_st_next = iidl_pkg::ST_FULL;
        end
    end

    assign ctrl.ins = accept && do_ins;
    assign ctrl.del = accept && do_del;

    always_comb begin
        len_next = len_reg;
        if (ctrl.ins) begin
            len_next = len_reg + LEN_W'(1);
        end else if (ctrl.del) begin
            len_next = len_reg - LEN_W'(1);
        end
    end

    // ---------------- cell chain ----------------
    logic [VW-1:0] cell_value [CAPACITY];
    logic [VW-1:0] cell_tap   [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [VW-1:0] left_v;
        logic [VW-1:0] right_v;
        if (i == 0) begin : g_first
            assign left_v = item_value;
        end else begin : g_mid_l
            assign left_v = cell_value[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_v = cell_value[i];
        end else begin : g_mid_r
            assign right_v = cell_value[i+1];
        end

        iidl_cell #(
            .IDX_W (LEN_W),
            .INDEX (i)
        ) u_cell (
            .aclk        (aclk),
            .ctrl        (ctrl),
            .at          (at),
            .new_value   (item_value),
            .left_value  (left_v),
            .right_value (right_v),
            .value       (cell_value[i]),
            .tap         (cell_tap[i])
        );
    end

    // Read bus: only the addressed cell taps a nonzero word.
    always_comb begin
        rd_bus = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            rd_bus = rd_bus | cell_tap[i];
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            if (accept) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    logic [6:0] len_out_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            out_rd_reg  <= out_rd_next;
            out_st_reg  <= out_st_next;
            len_out_reg <= 7'(len_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, len_out_reg, out_st_reg, out_rd_reg};

endmodule

// ----- rtl/iidl_checker.sv -----
// ----------------------------------------------------------------------------
// iidl_checker
// Port-level checks for the indexed insert/delete list core, bound to the top.
// ----------------------------------------------------------------------------
module iidl_checker #(
    parameter int unsigned CAPACITY = 64
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    // Reset leaves no result pending.
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // Every request beat gives a result on the next cycle.
    a_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> m_tvalid)
        else $error("request beat produced no result");

    // A held result does not change.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

    // A dropped insert reports no read value.
    a_full_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[33:32] == iidl_pkg::ST_FULL)) |-> (m_tdata[31:0] == 32'd0))
        else $error("full status with nonzero read value");

    // Reported length never exceeds the capacity.
    a_len_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ((CAPACITY > 127) || (32'(m_tdata[40:34]) <= CAPACITY)))
        else $error("length above capacity");

endmodule

bind indexed_insert_delete_list_core iidl_checker #(
    .CAPACITY (CAPACITY)
) u_iidl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ----- bench/indexed_insert_delete_list_core_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// indexed_insert_delete_list_core_tb
// Self-checking bench for the indexed insert/delete list core. Requests are
// streamed in with random gaps and results drained with random stalls. A
// shadow copy of the list predicts every result beat, and a scoreboard
// compares each beat field by field, in order.
// ----------------------------------------------------------------------------
module indexed_insert_delete_list_core_tb;

    localparam int unsigned LIST_CAPACITY = 64;
    localparam int          CLK_HALF      = 4;         // 8 ns clock
    localparam int          RESET_CYCLES  = 8;
    localparam int          RANDOM_ITEMS  = 1000;
    localparam int          LONG_HOLD     = 150;       // receiver hold-off, cycles
    localparam int          DRAIN_CYCLES  = 10;        // settle time after last beat
    localparam int          MAX_PRINTED   = 40;        // mismatch lines shown
    localparam int unsigned KIND_BITS     = iidl_pkg::KIND_W;

    // kind codes with no operation behind them; the core must flag them
    localparam logic [iidl_pkg::KIND_W-1:0] KIND_UNUSED_LO = 3'd5;
    localparam logic [iidl_pkg::KIND_W-1:0] KIND_UNUSED_HI = 3'd7;

    // how random traffic leans: toward a full list, an empty one, or neither
    typedef enum int {MIX_GROW, MIX_SHRINK, MIX_EVEN} traffic_mix_t;

    typedef struct {
        logic [iidl_pkg::VALUE_W-1:0]  read_value;
        iidl_pkg::status_t             status;
        logic [iidl_pkg::LENOUT_W-1:0] length_now;
    } list_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow list plus queue of predicted result beats.
    // ------------------------------------------------------------------------
    class list_result_scoreboard;
        logic [iidl_pkg::VALUE_W-1:0] cells [LIST_CAPACITY];
        int unsigned                  fill;
        list_result_t                 pending_results [$];
        int unsigned                  mismatches;

        function new();
            fill       = 0;
            mismatches = 0;
        endfunction

        // open a slot at 'at' and shift the tail up
        function iidl_pkg::status_t open_slot(int unsigned at,
                                              logic [iidl_pkg::VALUE_W-1:0] value);
            if (fill >= LIST_CAPACITY)
                return iidl_pkg::ST_FULL;
            for (int unsigned i = fill; i > at; i--)
                cells[i] = cells[i-1];
            cells[at] = value;
            fill++;
            return iidl_pkg::ST_DONE;
        endfunction

        function void note_request(logic [iidl_pkg::KIND_W-1:0] kind,
                                   logic signed [iidl_pkg::POS_W-1:0] position,
                                   logic [iidl_pkg::VALUE_W-1:0] value);
            list_result_t want;
            longint       pos;
            longint       len;
            pos             = position;
            len             = fill;
            want.read_value = '0;
            want.status     = iidl_pkg::ST_DONE;
            case (kind)
                iidl_pkg::KIND_READ: begin
                    if (pos < 0 || pos >= len) begin
                        want.read_value = '1;
                        want.status     = iidl_pkg::ST_RANGE;
                    end else begin
                        want.read_value = cells[int'(pos)];
                    end
                end
                iidl_pkg::KIND_HEAD:   want.status = open_slot(0, value);
                iidl_pkg::KIND_TAIL:   want.status = open_slot(fill, value);
                iidl_pkg::KIND_INSERT: begin
                    // range check beats the full check
                    if (pos == len)
                        want.status = open_slot(fill, value);
                    else if (pos <= 0)
                        want.status = open_slot(0, value);
                    else if (pos > len)
                        want.status = iidl_pkg::ST_RANGE;
                    else
                        want.status = open_slot(int'(pos), value);
                end
                iidl_pkg::KIND_DELETE: begin
                    if (pos < 0 || pos >= len) begin
                        want.status = iidl_pkg::ST_RANGE;
                    end else begin
                        for (int unsigned i = int'(pos); i + 1 < fill; i++)
                            cells[i] = cells[i+1];
                        fill--;
                    end
                end
                default: want.status = iidl_pkg::ST_RANGE;
            endcase
            want.length_now = fill[iidl_pkg::LENOUT_W-1:0];
            pending_results.push_back(want);
        endfunction

        task report_mismatch(string msg);
            mismatches++;
            if (mismatches <= MAX_PRINTED)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task check_result(logic [47:0] beat);
            logic [iidl_pkg::VALUE_W-1:0]  got_value;
            logic [iidl_pkg::STATUS_W-1:0] got_status;
            logic [iidl_pkg::LENOUT_W-1:0] got_len;
            list_result_t                  want;
            got_value  = beat[31:0];
            got_status = beat[33:32];
            got_len    = beat[40:34];
            if (pending_results.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
                return;
            end
            want = pending_results.pop_front();
            if (got_value !== want.read_value)
                report_mismatch($sformatf("read_value got %h want %h",
                                          got_value, want.read_value));
            if (got_status !== want.status)
                report_mismatch($sformatf("status got %0d want %0d",
                                          got_status, want.status));
            if (got_len !== want.length_now)
                report_mismatch($sformatf("length_now got %0d want %0d",
                                          got_len, want.length_now));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT hookup; every input starts known
    // ------------------------------------------------------------------------
    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata  = '0;     // position[31:0], item_value[63:32]
    logic [2:0]  s_tuser  = '0;     // kind[2:0]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;           // read_value[31:0], status[33:32],
                                    // length_now[40:34], zeros[47:41]

    indexed_insert_delete_list_core #(
        .CAPACITY (LIST_CAPACITY)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    list_result_scoreboard sb = new();

    // knobs shared by the sender, the receiver and the sequence
    bit send_idle_on    = 1'b1;
    bit recv_idle_on    = 1'b1;
    int hold_off_cycles = 0;        // nonzero asks the receiver for a long stall

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // Hard stop, far above the slowest legal run.
    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int random_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random stalls, plus the long hold-off on request. The
    // hold-off is counted here so the sender keeps pushing meanwhile.
    // ------------------------------------------------------------------------
    initial begin
        int gap;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (hold_off_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (hold_off_cycles) @(posedge aclk);
                hold_off_cycles = 0;
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            if (recv_idle_on) begin
                gap = random_gap();
                if (gap > 0) begin
                    m_tready <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
        end
    end

    // Result beats are sampled at the edge, before the DUT's own updates land.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // One request beat: hold valid until the core takes it, then log the
    // prediction and maybe idle. Valid stays high across back-to-back beats.
    task automatic send_request(input logic [iidl_pkg::KIND_W-1:0]  kind,
                                input logic [iidl_pkg::POS_W-1:0]   position,
                                input logic [iidl_pkg::VALUE_W-1:0] value);
        int gap;
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {value, position};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(kind, position, value);
        if (send_idle_on) begin
            gap = random_gap();
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                s_tdata  <= {$urandom(), $urandom()};   // junk while idle
                repeat (gap) @(posedge aclk);
            end
        end
    endtask

    // Drop valid so the last beat is not taken again, then wait for the drain.
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge aclk);
    endtask

    // Value: mostly random, sometimes one of the corner values.
    function automatic logic [iidl_pkg::VALUE_W-1:0] random_value();
        case ($urandom_range(0, 19))
            0:       return 32'h0000_0000;
            1:       return 32'hFFFF_FFFF;
            2:       return 32'h7FFF_FFFF;
            3:       return 32'h8000_0000;
            default: return $urandom();
        endcase
    endfunction

    // Position: mostly inside the list, some on its edges, some anywhere.
    function automatic logic [iidl_pkg::POS_W-1:0] random_position();
        int r;
        int len;
        r   = $urandom_range(0, 99);
        len = sb.fill;
        if (r < 70)
            return (len == 0) ? 0 : $urandom_range(0, len - 1);
        if (r < 80)
            return len;
        if (r < 85)
            return len + 1;
        if (r < 90)
            return -$urandom_range(1, 3);
        return $urandom();
    endfunction

    function automatic logic [iidl_pkg::KIND_W-1:0] random_unused_kind();
        return KIND_BITS'($urandom_range(KIND_UNUSED_LO, KIND_UNUSED_HI));
    endfunction

    task automatic send_random(input traffic_mix_t mix);
        int                          r;
        logic [iidl_pkg::KIND_W-1:0] kind;
        r = $urandom_range(0, 99);
        // cut points: read | head | tail | insert | delete | unused
        case (mix)
            MIX_GROW: begin
                if      (r < 13) kind = iidl_pkg::KIND_READ;
                else if (r < 33) kind = iidl_pkg::KIND_HEAD;
                else if (r < 53) kind = iidl_pkg::KIND_TAIL;
                else if (r < 85) kind = iidl_pkg::KIND_INSERT;
                else if (r < 98) kind = iidl_pkg::KIND_DELETE;
                else             kind = random_unused_kind();
            end
            MIX_SHRINK: begin
                if      (r < 20) kind = iidl_pkg::KIND_READ;
                else if (r < 25) kind = iidl_pkg::KIND_HEAD;
                else if (r < 30) kind = iidl_pkg::KIND_TAIL;
                else if (r < 40) kind = iidl_pkg::KIND_INSERT;
                else if (r < 98) kind = iidl_pkg::KIND_DELETE;
                else             kind = random_unused_kind();
            end
            default: begin
                if      (r < 25) kind = iidl_pkg::KIND_READ;
                else if (r < 40) kind = iidl_pkg::KIND_HEAD;
                else if (r < 55) kind = iidl_pkg::KIND_TAIL;
                else if (r < 75) kind = iidl_pkg::KIND_INSERT;
                else if (r < 98) kind = iidl_pkg::KIND_DELETE;
                else             kind = random_unused_kind();
            end
        endcase
        send_request(kind, random_position(), random_value());
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        int           items_sent;
        int           phase;
        int           n;
        traffic_mix_t mix;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // -- directed: empty list, edge positions, corner values, odd kinds
        send_request(iidl_pkg::KIND_READ,   0, 0);                 // read on empty list
        send_request(iidl_pkg::KIND_DELETE, 0, 0);                 // delete on empty list
        send_request(iidl_pkg::KIND_INSERT, 0, 32'h7FFF_FFFF);     // pos == len: append
        send_request(iidl_pkg::KIND_HEAD,   0, 32'h8000_0000);
        send_request(iidl_pkg::KIND_TAIL,   0, 32'h0000_0000);
        send_request(iidl_pkg::KIND_TAIL,   0, 32'hFFFF_FFFF);
        send_request(iidl_pkg::KIND_INSERT, 32'h8000_0000, 32'd5); // most negative: head
        send_request(iidl_pkg::KIND_INSERT, sb.fill, 32'd6);       // at length: append
        send_request(iidl_pkg::KIND_INSERT, 100, 32'd7);           // past length: flagged
        send_request(iidl_pkg::KIND_INSERT, 2, 32'h5A5A_5A5A);     // middle
        send_request(iidl_pkg::KIND_READ,   0, 0);
        send_request(iidl_pkg::KIND_READ,   sb.fill - 1, 0);
        send_request(iidl_pkg::KIND_READ,   sb.fill, 0);           // one past the end
        send_request(iidl_pkg::KIND_READ,   32'hFFFF_FFFF, 0);     // -1
        send_request(iidl_pkg::KIND_READ,   32'h7FFF_FFFF, 0);
        send_request(iidl_pkg::KIND_READ,   32'h8000_0000, 0);
        send_request(iidl_pkg::KIND_DELETE, 32'hFFFF_FFFF, 0);
        send_request(iidl_pkg::KIND_DELETE, sb.fill, 0);
        send_request(iidl_pkg::KIND_DELETE, 3, 0);
        send_request(iidl_pkg::KIND_DELETE, 0, 0);
        send_request(iidl_pkg::KIND_DELETE, sb.fill - 1, 0);
        for (int k = KIND_UNUSED_LO; k <= KIND_UNUSED_HI; k++)
            send_request(k[iidl_pkg::KIND_W-1:0], $urandom(), $urandom());

        // -- fill to capacity back to back while the result side holds off,
        //    so the core backs up and drops s_tready
        send_idle_on    = 1'b0;
        hold_off_cycles = LONG_HOLD;
        repeat (LIST_CAPACITY + 6) begin
            case ($urandom_range(0, 2))
                0:       send_request(iidl_pkg::KIND_HEAD, 0, random_value());
                1:       send_request(iidl_pkg::KIND_TAIL, 0, random_value());
                default: send_request(iidl_pkg::KIND_INSERT, $urandom_range(0, sb.fill),
                                      random_value());
            endcase
        end
        // full list: inserts drop but the past-length one; then a delete frees a slot
        send_request(iidl_pkg::KIND_HEAD,   0, 32'd11);
        send_request(iidl_pkg::KIND_TAIL,   0, 32'd12);
        send_request(iidl_pkg::KIND_INSERT, 0, 32'd13);
        send_request(iidl_pkg::KIND_INSERT, sb.fill, 32'd14);
        send_request(iidl_pkg::KIND_INSERT, sb.fill + 1, 32'd15);
        send_request(iidl_pkg::KIND_INSERT, sb.fill / 2, 32'd16);
        send_request(iidl_pkg::KIND_READ,   sb.fill - 1, 0);
        send_request(iidl_pkg::KIND_READ,   sb.fill, 0);
        send_request(iidl_pkg::KIND_DELETE, sb.fill - 1, 0);
        send_request(iidl_pkg::KIND_INSERT, sb.fill / 2, 32'd17);

        // -- sender pauses until every result is back
        send_idle_on = 1'b1;
        wait_for_results();

        // -- random traffic in phases that lean toward full, empty, or neither
        items_sent = 0;
        phase      = 0;
        while (items_sent < RANDOM_ITEMS) begin
            mix          = traffic_mix_t'(phase % 3);
            send_idle_on = ($urandom_range(0, 3) != 0);
            recv_idle_on = ($urandom_range(0, 3) != 0);
            if (phase == 4)
                hold_off_cycles = LONG_HOLD;
            if (phase == 7)
                wait_for_results();
            n = $urandom_range(60, 120);
            repeat (n) send_random(mix);
            items_sent += n;
            phase++;
        end

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatches == 0 && sb.pending_results.size() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
